>>> hdl/stdc_pkg.sv
package stdc_pkg;

	// Operation codes carried in the op field.
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_LOAD  = 2'd1;
	localparam logic [1:0] OP_START = 2'd2;
	localparam logic [1:0] OP_STOP  = 2'd3;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ON_HR   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ON_MIN  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OFF_HR  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OFF_MIN = 3'd4;
	localparam int unsigned CFG_DATA_W = 6;

	// Time limits.
	localparam logic [5:0] SECS_PER_MIN = 6'd60;
	localparam logic [5:0] LAST_MINUTE  = 6'd59;
	localparam logic [4:0] LAST_HOUR    = 5'd23;

	// Clock state that persists between items.
	typedef struct packed {
		logic [4:0] hours;
		logic [5:0] minutes;
		logic [5:0] seconds;
		logic [2:0] phase;
		logic       running;
		logic       light;
	} clk_state_t;

	// Configuration register contents.
	typedef struct packed {
		logic [2:0] speed;
		logic [4:0] on_hour;
		logic [5:0] on_minute;
		logic [4:0] off_hour;
		logic [5:0] off_minute;
	} clk_cfg_t;

	// Minute step pattern over the advanced phase and the multiplier.
	function automatic logic minute_step(input logic [2:0] ph, input logic [2:0] mul);
		logic res;
		case (ph)
			3'd0, 3'd4:       res = 1'b1;
			3'd1, 3'd3, 3'd5: res = (mul > 3'd2);
			3'd2:             res = (mul == 3'd2) || (mul == 3'd4);
			3'd6:             res = (mul != 3'd1) && (mul != 3'd3);
			default:          res = (mul == 3'd3) || (mul == 3'd4);
		endcase
		return res;
	endfunction

endpackage

>>> hdl/stdc_step.sv
module stdc_step (
	input  stdc_pkg::clk_state_t cur,
	input  stdc_pkg::clk_cfg_t   cfg,
	input  logic [1:0]           op,
	input  logic [4:0]           load_hours,
	input  logic [5:0]           load_minutes,
	output stdc_pkg::clk_state_t nxt,
	output logic                 action
);

	logic [6:0]  sec_sum;
	logic [5:0]  sec_wrap;
	logic [2:0]  phase_inc;
	logic        do_minute;
	logic [4:0]  hour_inc;
	logic [5:0]  min_inc;
	logic [10:0] now_key;
	logic [10:0] on_key;
	logic [10:0] off_key;
	logic        in_on;
	logic        in_off;

	// Seconds advance by the multiplier; the sum stays below twice sixty.
	assign sec_sum   = {1'b0, cur.seconds} + {4'd0, cfg.speed};
	assign sec_wrap  = (sec_sum >= {1'b0, stdc_pkg::SECS_PER_MIN}) ?
		6'(sec_sum - {1'b0, stdc_pkg::SECS_PER_MIN}) : sec_sum[5:0];
	assign phase_inc = cur.phase + 3'd1;
	assign do_minute = stdc_pkg::minute_step(phase_inc, cfg.speed);

	// Minute and hour roll-over after a minute step.
	always_comb begin
		if (cur.minutes >= stdc_pkg::LAST_MINUTE) begin
			min_inc  = 6'd0;
			hour_inc = (cur.hours >= stdc_pkg::LAST_HOUR) ? 5'd0 : cur.hours + 5'd1;
		end else begin
			min_inc  = cur.minutes + 6'd1;
			hour_inc = cur.hours;
		end
	end

	// Night window check on the stepped time.
	assign now_key = {hour_inc, min_inc};
	assign on_key  = {cfg.on_hour, cfg.on_minute};
	assign off_key = {cfg.off_hour, cfg.off_minute};
	assign in_on   = (now_key >= on_key) || (now_key <= off_key);
	assign in_off  = (now_key < on_key) && (now_key > off_key);

	// Next state per operation.
	always_comb begin
		nxt    = cur;
		action = 1'b0;
		case (op)
			stdc_pkg::OP_TICK: begin
				if (cur.running) begin
					nxt.seconds = sec_wrap;
					nxt.phase   = phase_inc;
					if (do_minute) begin
						nxt.minutes = min_inc;
						nxt.hours   = hour_inc;
						if (in_on && !cur.light) begin
							nxt.light = 1'b1;
							action    = 1'b1;
						end else if (in_off && cur.light) begin
							nxt.light = 1'b0;
							action    = 1'b1;
						end
					end
				end
			end
			stdc_pkg::OP_LOAD: begin
				nxt.hours   = load_hours;
				nxt.minutes = load_minutes;
			end
			stdc_pkg::OP_START: begin
				nxt.running = 1'b1;
			end
			default: begin
				nxt.running = 1'b0;
				nxt.seconds = 6'd0;
				nxt.light   = 1'b0;
				action      = 1'b1;
			end
		endcase
	end

endmodule

>>> hdl/scaled_time_of_day_clock.sv
// An input transfer is captured in the input register; the time update then writes
// its result into the result register, which drives m_tvalid.
// Throughput: one item per cycle while m_tready holds; the clock state feeds back
// through a single update step, so each item sees the state left by the one before it.
// Reset: asynchronous, active low; clears the time, phase, run and light state
// and returns the configuration registers to their reset values.
module scaled_time_of_day_clock (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [15:0]                      s_tdata,  // op[1:0], load_hours[6:2], load_minutes[12:7]
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [23:0]                      m_tdata,  // cur_hours[4:0], cur_minutes[10:5],
	                                                   // cur_seconds[16:11], light_on[17], light_action[18]
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [stdc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [stdc_pkg::CFG_DATA_W-1:0]  cfg_data
);

	logic                  valid_s1;
	logic [1:0]            op_s1;
	logic [4:0]            hours_s1;
	logic [5:0]            minutes_s1;
	logic                  advance;
	stdc_pkg::clk_state_t  state_q;
	stdc_pkg::clk_state_t  state_nxt;
	stdc_pkg::clk_cfg_t    cfg_q;
	logic                  action;
	logic                  out_valid_q;
	logic [23:0]           out_data_q;

	assign cfg_ready = 1'b1;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.speed      <= 3'd1;
			cfg_q.on_hour    <= 5'd0;
			cfg_q.on_minute  <= 6'd0;
			cfg_q.off_hour   <= 5'd0;
			cfg_q.off_minute <= 6'd0;
		end else if (cfg_valid) begin
			case (cfg_index)
				stdc_pkg::REG_SPEED:   cfg_q.speed      <= cfg_data[2:0];
				stdc_pkg::REG_ON_HR:   cfg_q.on_hour    <= cfg_data[4:0];
				stdc_pkg::REG_ON_MIN:  cfg_q.on_minute  <= cfg_data;
				stdc_pkg::REG_OFF_HR:  cfg_q.off_hour   <= cfg_data[4:0];
				stdc_pkg::REG_OFF_MIN: cfg_q.off_minute <= cfg_data;
				default: ;
			endcase
		end
	end

	// The update step moves when the result register is free or being drained.
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1      <= s_tdata[1:0];
			hours_s1   <= s_tdata[6:2];
			minutes_s1 <= s_tdata[12:7];
		end
	end

	stdc_step u_step (
		.cur          (state_q),
		.cfg          (cfg_q),
		.op           (op_s1),
		.load_hours   (hours_s1),
		.load_minutes (minutes_s1),
		.nxt          (state_nxt),
		.action       (action)
	);

	// Clock state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {5'd0, action, state_nxt.light, state_nxt.seconds,
				state_nxt.minutes, state_nxt.hours};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule
